// ----- rtl/tcs_pkg.sv -----
// Shared types and constants for the time tag coincidence sifter.
// Used by tcs_front, tcs_back and time_tag_coincidence_sifter; depends on nothing.
package tcs_pkg;

  localparam int TIME_WIDTH            = 60;
  localparam int MASK_WIDTH            = 4;
  localparam int TAG_WIDTH             = 64;
  localparam int OUT_WIDTH             = 32;
  localparam int WINDOW_WIDTH          = 32;
  localparam int SHIFT_WIDTH           = 42;
  localparam int DIFF_WIDTH            = TIME_WIDTH + 2;
  localparam int CFG_INDEX_WIDTH       = 2;
  localparam int CFG_DATA_WIDTH        = 42;
  localparam int COUNTER_WIDTH_DEFAULT = 32;
  localparam int QUEUE_DEPTH_DEFAULT   = 4;

  localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = 32'd1500;

  // Detector mask groups of the two bases.
  localparam logic [MASK_WIDTH-1:0] DIAG_BITS = 4'h3;
  localparam logic [MASK_WIDTH-1:0] RECT_BITS = 4'hC;

  // Basis codes reported with a coincidence.
  localparam logic [1:0] BASIS_NONE = 2'd0;
  localparam logic [1:0] BASIS_HV   = 2'd1;
  localparam logic [1:0] BASIS_AD   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SHIFT  = 2'd1;

  typedef struct packed {
    logic                 from_bob;
    logic [TAG_WIDTH-1:0] tag_word;
  } tag_t;

  // A tag after decoding, as it waits in the queue.
  typedef struct packed {
    logic                  from_bob;
    logic [TIME_WIDTH-1:0] stamp;
    logic [MASK_WIDTH-1:0] mask;
  } entry_t;

  typedef struct packed {
    logic                    next_side;
    logic                    coincidence;
    logic [OUT_WIDTH-1:0]    alice_index;
    logic [OUT_WIDTH-1:0]    bob_index;
    logic [1:0]              basis_code;
    logic                    bit_error;
    logic [OUT_WIDTH-1:0]    coincidence_total;
    logic [OUT_WIDTH-1:0]    sifted_total;
    logic [OUT_WIDTH-1:0]    error_total;
    logic [OUT_WIDTH-1:0]    hv_total;
    logic [OUT_WIDTH-1:0]    ad_total;
    logic [OUT_WIDTH-1:0]    hv_errors;
  } result_t;

  typedef struct packed {
    logic [WINDOW_WIDTH-1:0]       window;
    logic signed [SHIFT_WIDTH-1:0] shift;
  } cfg_t;

  // Head of the queue as the back end sees it.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_head_t;

endpackage

// ----- rtl/tcs_front.sv -----
// Front end of the sifter: accepts tag items, splits each tag word into
// time and mask, and holds them in a short queue. Depends on tcs_pkg.
module tcs_front import tcs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        tag_valid,
  output logic        tag_stall,
  input  tag_t        tag_item,
  output queue_head_t head,
  input  logic        pop
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t          slots [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            do_pop;
  entry_t          decoded;

  assign tag_stall = (count == CW'(QUEUE_DEPTH));
  assign push      = tag_valid && !tag_stall;
  assign do_pop    = pop && (count != '0);

  always_comb begin
    decoded.from_bob = tag_item.from_bob;
    decoded.stamp    = tag_item.tag_word[TAG_WIDTH-1:MASK_WIDTH];
    decoded.mask     = tag_item.tag_word[MASK_WIDTH-1:0];
  end

  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(do_pop);
    end
  end

endmodule

// ----- rtl/tcs_back.sv -----
// Back end of the sifter: holds the head tag of each side, matches them,
// keeps ordinals and counters, and owns the result register. Depends on tcs_pkg.
module tcs_back import tcs_pkg::*; #(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  queue_head_t head,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result_item
);

  localparam int OW = (COUNTER_WIDTH < OUT_WIDTH) ? COUNTER_WIDTH : OUT_WIDTH;

  logic [TIME_WIDTH-1:0]    alice_time, bob_time;
  logic [MASK_WIDTH-1:0]    alice_mask, bob_mask;
  logic                     alice_held, bob_held;
  logic [COUNTER_WIDTH-1:0] alice_ordinal, bob_ordinal;
  logic [COUNTER_WIDTH-1:0] coinc_counter, sift_counter, err_counter;
  logic [COUNTER_WIDTH-1:0] hv_counter, ad_counter, hv_err_counter;

  logic [TIME_WIDTH-1:0]    alice_time_next, bob_time_next;
  logic [MASK_WIDTH-1:0]    alice_mask_next, bob_mask_next;
  logic                     alice_held_next, bob_held_next;
  logic                     take, both;
  logic signed [DIFF_WIDTH-1:0] diff, half;
  logic                     late, early, coin, ad_hit, hv_hit, mismatch;
  logic                     alice_done, bob_done;
  logic                     alice_held_after;
  result_t                  result_next;

  function automatic logic [OUT_WIDTH-1:0] low_out(input logic [COUNTER_WIDTH-1:0] c);
    return OUT_WIDTH'(c[OW-1:0]);
  endfunction

  // A new item may enter the result register when it is empty or being taken.
  assign pop = head.valid && (!result_valid || !result_stall);

  always_comb begin
    take            = (head.entry.from_bob == alice_held);
    alice_time_next = alice_time;
    alice_mask_next = alice_mask;
    alice_held_next = alice_held;
    bob_time_next   = bob_time;
    bob_mask_next   = bob_mask;
    bob_held_next   = bob_held;
    if (take && !head.entry.from_bob) begin
      alice_time_next = head.entry.stamp;
      alice_mask_next = head.entry.mask;
      alice_held_next = 1'b1;
    end
    if (take && head.entry.from_bob) begin
      bob_time_next = head.entry.stamp;
      bob_mask_next = head.entry.mask;
      bob_held_next = 1'b1;
    end
  end

  always_comb begin
    both  = alice_held_next && bob_held_next;
    diff  = $signed({2'b00, bob_time_next}) - $signed({2'b00, alice_time_next})
            + DIFF_WIDTH'(cfg.shift);
    half  = $signed(DIFF_WIDTH'(cfg.window[WINDOW_WIDTH-1:1]));
    late  = diff > half;
    early = diff < -half;
    coin  = both && !late && !early;
    alice_done = both && !early;
    bob_done   = both && !late;
    ad_hit   = |(alice_mask_next & DIAG_BITS) && |(bob_mask_next & DIAG_BITS);
    hv_hit   = |(alice_mask_next & RECT_BITS) && |(bob_mask_next & RECT_BITS) && !ad_hit;
    mismatch = (alice_mask_next != bob_mask_next);
    alice_held_after = alice_held_next && !alice_done;
  end

  always_comb begin
    result_next                   = '0;
    result_next.next_side         = alice_held_after;
    result_next.coincidence       = coin;
    if (coin) begin
      result_next.alice_index = low_out(alice_ordinal);
      result_next.bob_index   = low_out(bob_ordinal);
      result_next.basis_code  = ad_hit ? BASIS_AD : (hv_hit ? BASIS_HV : BASIS_NONE);
      result_next.bit_error   = (ad_hit || hv_hit) && mismatch;
    end
    result_next.coincidence_total = low_out(coinc_counter + COUNTER_WIDTH'(coin));
    result_next.sifted_total      = low_out(sift_counter
                                    + COUNTER_WIDTH'(coin && (ad_hit || hv_hit)));
    result_next.error_total       = low_out(err_counter
                                    + COUNTER_WIDTH'(coin && (ad_hit || hv_hit) && mismatch));
    result_next.hv_total          = low_out(hv_counter + COUNTER_WIDTH'(coin && hv_hit));
    result_next.ad_total          = low_out(ad_counter + COUNTER_WIDTH'(coin && ad_hit));
    result_next.hv_errors         = low_out(hv_err_counter
                                    + COUNTER_WIDTH'(coin && hv_hit && mismatch));
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      alice_time  <= alice_time_next;
      alice_mask  <= alice_mask_next;
      bob_time    <= bob_time_next;
      bob_mask    <= bob_mask_next;
      result_item <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alice_held     <= 1'b0;
      bob_held       <= 1'b0;
      alice_ordinal  <= '0;
      bob_ordinal    <= '0;
      coinc_counter  <= '0;
      sift_counter   <= '0;
      err_counter    <= '0;
      hv_counter     <= '0;
      ad_counter     <= '0;
      hv_err_counter <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (pop) begin
        alice_held    <= alice_held_after;
        bob_held      <= bob_held_next && !bob_done;
        alice_ordinal <= alice_ordinal + COUNTER_WIDTH'(alice_done);
        bob_ordinal   <= bob_ordinal + COUNTER_WIDTH'(bob_done);
        coinc_counter <= coinc_counter + COUNTER_WIDTH'(coin);
        sift_counter  <= sift_counter + COUNTER_WIDTH'(coin && (ad_hit || hv_hit));
        err_counter   <= err_counter
                         + COUNTER_WIDTH'(coin && (ad_hit || hv_hit) && mismatch);
        hv_counter     <= hv_counter + COUNTER_WIDTH'(coin && hv_hit);
        ad_counter     <= ad_counter + COUNTER_WIDTH'(coin && ad_hit);
        hv_err_counter <= hv_err_counter + COUNTER_WIDTH'(coin && hv_hit && mismatch);
        result_valid   <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/time_tag_coincidence_sifter.sv -----
// An accepted tag item is queued first; its result is registered as it leaves the queue.
// Throughput: one item per cycle unless stalled; the result register and the front queue
// let both sides stall independently; queue depth sets how many items are taken under stall.
// Reset (rst, synchronous, active high) empties the queue, drops both held heads, clears
// the ordinals and all totals, and sets the window to 1500 and the delay shift to 0.
// Top level of the time tag coincidence sifter; depends on tcs_pkg, tcs_front, tcs_back.
module time_tag_coincidence_sifter import tcs_pkg::*; #(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  // Tag items in.
  input  logic                       tag_valid,
  output logic                       tag_stall,
  input  tag_t                       tag_item,
  // Result items out.
  output logic                       result_valid,
  input  logic                       result_stall,
  output result_t                    result_item,
  // Configuration writes.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  // The configuration registers live here. Writes are always taken; an index beyond
  // the two defined registers is simply dropped. The user must write only while the block
  // is idle, unchecked by the block, so the back end can read these registers directly.
  cfg_t        cfg;
  queue_head_t head;
  logic        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window <= WINDOW_RESET;
      cfg.shift  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW: cfg.window <= cfg_data[WINDOW_WIDTH-1:0];
        CFG_SHIFT:  cfg.shift  <= $signed(cfg_data[SHIFT_WIDTH-1:0]);
        default: begin
        end
      endcase
    end
  end

  // The front end only decodes and queues tags. Whether a tag belongs to the
  // side the sifter wants depends on the held heads, so every item is queued
  // and the back end decides; a tag for the other side still gives a result.
  tcs_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .tag_valid(tag_valid),
    .tag_stall(tag_stall),
    .tag_item (tag_item),
    .head     (head),
    .pop      (pop)
  );

  // The back end handles one queued item per cycle unless the result is stalled: a tag for
  // the side it wants is loaded into that side's head; it forms bob minus alice plus the shift,
  // compares against half the window, and updates ordinals and totals in the same cycle.
  tcs_back #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_item (result_item)
  );

  // A new result appears only when an item left the queue the cycle before.
  a_result_from_queue: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(pop && head.valid))
    else $error("result appeared without a queued item");

  // An error is only reported on a coincidence with a matched basis.
  a_error_needs_basis: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_item.bit_error) |->
      (result_item.coincidence && result_item.basis_code != BASIS_NONE))
    else $error("bit error without a matched basis");

  // Without a coincidence the per-match fields stay zero.
  a_quiet_when_no_match: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_item.coincidence) |->
      (result_item.alice_index == '0 && result_item.bob_index == '0 &&
       result_item.basis_code == BASIS_NONE))
    else $error("match fields set without a coincidence");

endmodule

// ----- bench/tb_time_tag_coincidence_sifter.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for time_tag_coincidence_sifter: a queue-fed driver and a monitor
// check every result item against a behavioral predictor. Depends on tcs_pkg and the RTL.
module tb_time_tag_coincidence_sifter;
  import tcs_pkg::*;

  // Stop when nothing at all has been accepted for this many cycles.
  localparam int QUIET_LIMIT   = 2000;
  // Cycles left to pass once nothing is expected, well beyond the result latency.
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;

  // Indexes past the last register; the block has to ignore writes to them.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_HI = 2'd3;

  // Everything the sifter remembers, plus the two configuration registers.
  typedef struct packed {
    logic [TIME_WIDTH-1:0]         alice_time;
    logic [TIME_WIDTH-1:0]         bob_time;
    logic [MASK_WIDTH-1:0]         alice_mask;
    logic [MASK_WIDTH-1:0]         bob_mask;
    logic                          alice_held;
    logic                          bob_held;
    logic [OUT_WIDTH-1:0]          alice_ord;
    logic [OUT_WIDTH-1:0]          bob_ord;
    logic [OUT_WIDTH-1:0]          coinc;
    logic [OUT_WIDTH-1:0]          sifted;
    logic [OUT_WIDTH-1:0]          errors;
    logic [OUT_WIDTH-1:0]          hv;
    logic [OUT_WIDTH-1:0]          ad;
    logic [OUT_WIDTH-1:0]          hv_err;
    logic [WINDOW_WIDTH-1:0]       window;
    logic signed [SHIFT_WIDTH-1:0] shift;
  } sifter_track_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       tag_valid    = 1'b0;
  logic                       tag_stall;
  tag_t                       tag_item     = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  result_t                    result_item;
  logic                       cfg_valid    = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index    = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data     = '0;

  // track_now follows the block item by item as tags are accepted; track_plan runs ahead
  // while stimulus is generated, so the generator knows which side the block will want.
  sifter_track_t   track_now;
  sifter_track_t   track_plan;
  tag_t            tag_backlog[$];
  result_t         sift_due[$];
  logic [TIME_WIDTH-1:0] tag_clock = '0;

  int idle_pct     = 0;
  int tag_gap      = 0;
  int stall_left   = 0;
  int quiet_cycles = 0;
  int mismatches   = 0;
  int results_seen = 0;

  time_tag_coincidence_sifter i_dut (
    .clk          (clk),
    .rst          (rst),
    .tag_valid    (tag_valid),
    .tag_stall    (tag_stall),
    .tag_item     (tag_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic sifter_track_t fresh_track();
    sifter_track_t t;
    t        = '0;
    t.window = WINDOW_RESET;
    return t;
  endfunction

  // One tag item through the sifter. The block wants alice while it holds no alice head,
  // otherwise bob; a tag for the other side leaves the state alone but still reports.
  function automatic result_t sift_tag(inout sifter_track_t st, input tag_t tag);
    result_t r;
    longint  half;
    longint  diff;
    longint  shift_ext;
    r = '0;
    if (tag.from_bob == st.alice_held) begin
      if (tag.from_bob) begin
        st.bob_time = tag.tag_word[TAG_WIDTH-1:MASK_WIDTH];
        st.bob_mask = tag.tag_word[MASK_WIDTH-1:0];
        st.bob_held = 1'b1;
      end else begin
        st.alice_time = tag.tag_word[TAG_WIDTH-1:MASK_WIDTH];
        st.alice_mask = tag.tag_word[MASK_WIDTH-1:0];
        st.alice_held = 1'b1;
      end
      if (st.alice_held && st.bob_held) begin
        // The difference is exact: 60-bit stamps plus a 42-bit shift fit a longint.
        half      = longint'({33'b0, st.window[WINDOW_WIDTH-1:1]});
        shift_ext = st.shift;
        diff      = longint'({4'b0, st.bob_time}) - longint'({4'b0, st.alice_time}) + shift_ext;
        if (diff > half) begin
          // Alice is too early to ever match: drop her head.
          st.alice_held = 1'b0;
          st.alice_ord  = st.alice_ord + 1'b1;
        end else if (diff < -half) begin
          st.bob_held = 1'b0;
          st.bob_ord  = st.bob_ord + 1'b1;
        end else begin
          r.coincidence = 1'b1;
          r.alice_index = st.alice_ord;
          r.bob_index   = st.bob_ord;
          st.coinc      = st.coinc + 1'b1;
          // The diagonal basis wins when both groups are hit on both sides.
          if ((st.alice_mask & DIAG_BITS) != '0 && (st.bob_mask & DIAG_BITS) != '0) begin
            r.basis_code = BASIS_AD;
            st.sifted    = st.sifted + 1'b1;
            st.ad        = st.ad + 1'b1;
            if (st.alice_mask != st.bob_mask) begin
              r.bit_error = 1'b1;
              st.errors   = st.errors + 1'b1;
            end
          end else if ((st.alice_mask & RECT_BITS) != '0 && (st.bob_mask & RECT_BITS) != '0) begin
            r.basis_code = BASIS_HV;
            st.sifted    = st.sifted + 1'b1;
            st.hv        = st.hv + 1'b1;
            if (st.alice_mask != st.bob_mask) begin
              r.bit_error = 1'b1;
              st.errors   = st.errors + 1'b1;
              st.hv_err   = st.hv_err + 1'b1;
            end
          end
          st.alice_held = 1'b0;
          st.bob_held   = 1'b0;
          st.alice_ord  = st.alice_ord + 1'b1;
          st.bob_ord    = st.bob_ord + 1'b1;
        end
      end
    end
    r.next_side         = st.alice_held;
    r.coincidence_total = st.coinc;
    r.sifted_total      = st.sifted;
    r.error_total       = st.errors;
    r.hv_total          = st.hv;
    r.ad_total          = st.ad;
    r.hv_errors         = st.hv_err;
    return r;
  endfunction

  function automatic void apply_reg(inout sifter_track_t st,
                                    input logic [CFG_INDEX_WIDTH-1:0] idx,
                                    input logic [CFG_DATA_WIDTH-1:0] data);
    if (idx == CFG_WINDOW) begin
      st.window = data[WINDOW_WIDTH-1:0];
    end else if (idx == CFG_SHIFT) begin
      st.shift = data[SHIFT_WIDTH-1:0];
    end
  endfunction

  // Adds one tag item to the backlog and lets the look-ahead copy take it too.
  task automatic queue_tag(input logic side, input logic [TAG_WIDTH-1:0] word);
    tag_t    tag;
    result_t unused;
    tag.from_bob = side;
    tag.tag_word = word;
    tag_backlog.push_back(tag);
    unused = sift_tag(track_plan, tag);
  endtask

  // Random tags, mostly for the side the block wants. A tag that faces a held head on the
  // other side is placed at a chosen difference from it: inside the window, on either edge,
  // just past an edge, or far off. About one item in ten is a fully random tag for the
  // wrong side, which the block has to ignore and which does not count.
  task automatic queue_random(input int count);
    int                    made;
    logic                  side;
    logic                  partner_held;
    logic [MASK_WIDTH-1:0] mask;
    logic [TAG_WIDTH-1:0]  rnd;
    logic [63:0]           stamp_wide;
    longint                half;
    longint                diff;
    longint                shift_ext;
    made = 0;
    while (made < count) begin
      side = track_plan.alice_held;
      rnd  = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) begin
        queue_tag(!side, rnd);
      end else begin
        partner_held = side ? track_plan.alice_held : track_plan.bob_held;
        mask         = rnd[MASK_WIDTH-1:0];
        if (!partner_held || $urandom_range(0, 15) == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            tag_clock = rnd[TAG_WIDTH-1:MASK_WIDTH];
          end else begin
            tag_clock = tag_clock + $urandom_range(1, 1 << 20);
          end
        end else begin
          half      = longint'({33'b0, track_plan.window[WINDOW_WIDTH-1:1]});
          shift_ext = track_plan.shift;
          case ($urandom_range(0, 5))
            0, 1:    diff = (longint'({32'b0, $urandom}) % (2 * half + 1)) - half;
            2:       diff = half;
            3:       diff = -half;
            4:       diff = $urandom_range(0, 1) ? half + 1 : -half - 1;
            default: begin
              diff = half + 1 + longint'($urandom_range(0, 1 << 16));
              if ($urandom_range(0, 1) == 0) diff = -diff;
            end
          endcase
          // Solve diff = bob - alice + shift for the stamp of the side being sent.
          if (side) begin
            stamp_wide = longint'({4'b0, track_plan.alice_time}) - shift_ext + diff;
          end else begin
            stamp_wide = longint'({4'b0, track_plan.bob_time}) + shift_ext - diff;
          end
          tag_clock = stamp_wide[TIME_WIDTH-1:0];
          if ($urandom_range(0, 1) == 0) begin
            mask = side ? track_plan.alice_mask : track_plan.bob_mask;
          end
        end
        queue_tag(side, {tag_clock, mask});
        made++;
      end
    end
  endtask

  // A register write; the block is idle whenever this is called, so both copies of the
  // predictor take the new value at once.
  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(track_now, idx, data);
    apply_reg(track_plan, idx, data);
  endtask

  // The sender holds off here until every expected result item has come back.
  task automatic drain_results();
    while (tag_backlog.size() != 0 || tag_valid || sift_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [WINDOW_WIDTH-1:0] window,
                           input logic [SHIFT_WIDTH-1:0] shift,
                           input int count, input int idle);
    logic [31:0] junk;
    junk = $urandom;
    // Bits above the window width ride along and must be dropped by the block.
    write_reg(CFG_WINDOW, {junk[CFG_DATA_WIDTH-WINDOW_WIDTH-1:0], window});
    write_reg(CFG_SHIFT, shift);
    idle_pct = idle;
    queue_random(count);
    drain_results();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
      end
    end
  endtask

  // Driver: a new tag item may go out only when the current one is gone or there is none.
  // When tag items are accepted, their expected results are worked out right away, in order.
  always @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
      tag_gap = 0;
    end else begin
      if (tag_valid && !tag_stall) begin
        sift_due.push_back(sift_tag(track_now, tag_item));
      end
      if (!tag_valid || !tag_stall) begin
        if (tag_gap > 0) begin
          tag_gap--;
          tag_valid <= 1'b0;
        end else if (tag_backlog.size() != 0) begin
          tag_item  <= tag_backlog.pop_front();
          tag_valid <= 1'b1;
          if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            tag_gap = $urandom_range(1, 6);
          end
        end else begin
          tag_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every accepted result item is matched against the oldest expectation, and
  // stall is raised in short random bursts while idling is enabled.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (sift_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("result %0d arrived with nothing expected", results_seen);
          end
        end else begin
          result_t want;
          want = sift_due.pop_front();
          check_field("next_side", want.next_side, result_item.next_side);
          check_field("coincidence", want.coincidence, result_item.coincidence);
          check_field("alice_index", want.alice_index, result_item.alice_index);
          check_field("bob_index", want.bob_index, result_item.bob_index);
          check_field("basis_code", want.basis_code, result_item.basis_code);
          check_field("bit_error", want.bit_error, result_item.bit_error);
          check_field("coincidence_total", want.coincidence_total,
                      result_item.coincidence_total);
          check_field("sifted_total", want.sifted_total, result_item.sifted_total);
          check_field("error_total", want.error_total, result_item.error_total);
          check_field("hv_total", want.hv_total, result_item.hv_total);
          check_field("ad_total", want.ad_total, result_item.ad_total);
          check_field("hv_errors", want.hv_errors, result_item.hv_errors);
        end
      end
      if (stall_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Watchdog: a hang on any channel shows up as a long run of cycles without a handshake.
  always @(posedge clk) begin
    if (rst || (tag_valid && !tag_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] rnd;
    track_now  = fresh_track();
    track_plan = fresh_track();

    // Directed items under the reset settings: window 1500, so half is 750, shift 0.
    // A bob tag straight after reset is for the wrong side and is ignored.
    queue_tag(1'b1, {60'd100, 4'h1});
    queue_tag(1'b0, {60'd1000, 4'h1});
    // A second alice tag while one alice head is held is ignored as well.
    queue_tag(1'b0, {60'd1100, 4'h2});
    // Differences of exactly plus and minus half still match: diagonal basis, clean then
    // with a bit error.
    queue_tag(1'b1, {60'd1750, 4'h1});
    queue_tag(1'b0, {60'd2000, 4'h2});
    queue_tag(1'b1, {60'd1250, 4'h1});
    // One past half drops the alice head; the next alice tag matches in the rectilinear
    // basis with an error.
    queue_tag(1'b0, {60'd3000, 4'h4});
    queue_tag(1'b1, {60'd3751, 4'h4});
    queue_tag(1'b0, {60'd3100, 4'h8});
    // One past minus half drops the bob head; then a clean rectilinear match.
    queue_tag(1'b0, {60'd5000, 4'h4});
    queue_tag(1'b1, {60'd4249, 4'h4});
    queue_tag(1'b1, {60'd5000, 4'h4});
    // Coincidences without a common basis, including empty masks.
    queue_tag(1'b0, {60'd6000, 4'h1});
    queue_tag(1'b1, {60'd6000, 4'h4});
    queue_tag(1'b0, {60'd7000, 4'h0});
    queue_tag(1'b1, {60'd7000, 4'h0});
    // Full masks pick the diagonal basis over the rectilinear one.
    queue_tag(1'b0, {60'd8000, 4'hF});
    queue_tag(1'b1, {60'd8000, 4'hF});
    queue_tag(1'b0, {60'd9000, 4'hF});
    queue_tag(1'b1, {60'd9000, 4'h7});
    // Extreme stamps: the largest negative and positive differences.
    queue_tag(1'b0, '1);
    queue_tag(1'b1, '0);
    queue_tag(1'b1, '1);
    queue_tag(1'b0, '0);
    queue_tag(1'b1, {{TIME_WIDTH{1'b1}}, 4'h8});
    queue_tag(1'b0, {{TIME_WIDTH{1'b1}}, 4'h8});

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    drain_results();

    // A zero window accepts only exact matches; the shift then sits at its negative end.
    run_phase(32'd0, 42'd0, 200, 20);
    run_phase(32'd1, {1'b1, 41'd0}, 200, 0);
    // Writes past the last register must leave the settings alone.
    rnd = {$urandom, $urandom};
    write_reg(CFG_SPARE_LO, rnd[CFG_DATA_WIDTH-1:0]);
    rnd = {$urandom, $urandom};
    write_reg(CFG_SPARE_HI, rnd[CFG_DATA_WIDTH-1:0]);
    run_phase('1, {1'b0, {41{1'b1}}}, 200, 25);
    rnd = {$urandom, $urandom};
    run_phase($urandom_range(0, 1 << 20),
              {{22{rnd[20]}}, rnd[19:0]}, 250, 15);
    rnd = {$urandom, $urandom};
    run_phase($urandom, rnd[CFG_DATA_WIDTH-1:0], 200, 15);
    run_phase(32'd1000, -42'sd123456, 250, 30);
    run_phase(32'd64, 42'd40, 150, 10);
    // The last stretch runs with no idling on either side.
    run_phase(WINDOW_RESET, 42'd0, 250, 0);

    if (mismatches == 0 && sift_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tcs_pkg.sv
rtl/tcs_front.sv
rtl/tcs_back.sv
rtl/time_tag_coincidence_sifter.sv
bench/tb_time_tag_coincidence_sifter.sv
